### src/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat send window.
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int PID_W      = 25;
   localparam int ACC_W      = 36;

   localparam logic [31:0] SRTT_RESET   = 32'd5000;
   localparam logic [31:0] DEV_RESET    = 32'd500;
   localparam logic [31:0] BOOST_LIMIT  = 32'd10000;
   localparam logic [10:0] ADAPT_RETRY  = 11'd1024;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_SCAN  = 2'd1,
      REQ_ACK   = 2'd2,
      REQ_TIMER = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_CONNACK = 3'd1,
      KIND_ABORT   = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_ACCEPT  = 3'd4,
      KIND_IGNORE  = 3'd5,
      KIND_IDLE    = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      SLOT_FINISHED = 3'd0,
      SLOT_TO_SEND  = 3'd1,
      SLOT_WAITING  = 3'd2,
      SLOT_ACKED    = 3'd3,
      SLOT_EXPIRED  = 3'd4
   } slot_status_type;

   typedef enum logic [2:0] {
      REG_WINDOW  = 3'd0,
      REG_PACKETS = 3'd1,
      REG_ADAPT   = 3'd2,
      REG_CLIENT  = 3'd3,
      REG_RETRIES = 3'd4,
      REG_TIMEOUT = 3'd5
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MOD,
      ST_SCAN_BASE,
      ST_SCAN_SLOT,
      ST_SCAN_CHK,
      ST_SCAN_SEND,
      ST_ACK_SLOT,
      ST_ACK_PID,
      ST_ACK_CHECK,
      ST_AD_E,
      ST_AD_S,
      ST_AD_D,
      ST_AD_X0,
      ST_AD_X1,
      ST_AD_CLAMP,
      ST_AD_T,
      ST_SLIDE_INIT,
      ST_SLIDE_BASE,
      ST_SLIDE,
      ST_SLIDE_END,
      ST_PUSH,
      ST_FINAL
   } state_type;

endpackage

### src/selective_repeat_send_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_send_window
// Selective-repeat ARQ sender: window slots, scan, ack slide and RTT estimate.
// ----------------------------------------------------------------------------
// Usage: one request word enters on req_* (start, scan, ack, timer expiry);
// the block then drops req_stall only when it is back in idle. Each request
// yields one or more result words on rsp_*, the final one marked by rsp_last.
// Configuration is written over the APB-style port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Every modulo, by the window or twice it, runs on one shared remainder unit,
// 5 bits per cycle. Start and timer go straight to the final word; an ack
// runs the estimator steps only in adaptive mode. The window walk visits one
// slot per cycle between sends. One result is held back so the last can be
// flagged; rsp_stall holds the output word and the sequencer waits on it.
// Reset clears control state: all slots finished, window empty, estimates at
// their defaults and the timeout at the initial timeout register's reset value.
// ----------------------------------------------------------------------------
module selective_repeat_send_window
   import srsw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [5:0]        req_ack_num,
   input  logic [4:0]        req_slot_index,
   input  logic [31:0]       req_rtt_sample,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [24:0]       rsp_packet_id,
   output logic [5:0]        rsp_seq_num,
   output logic              rsp_is_resend,
   output logic [31:0]       rsp_timeout_value,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // configuration
   logic [5:0]  window_size_ff;
   logic [23:0] packet_count_ff;
   logic        adaptive_ff, client_ff;
   logic [9:0]  retries_ff;
   logic [31:0] init_to_ff;

   // window slots
   logic [2:0]       slot_status_ff [MAX_WINDOW];
   logic [PID_W-1:0] slot_pid_ff    [MAX_WINDOW];
   logic             slot_resent_ff [MAX_WINDOW];

   // state
   state_type state_ff, state_in, mod_ret_ff, mod_ret_in, push_ret_ff, push_ret_in;
   logic [PID_W-1:0] next_exp_ff, next_exp_in;
   logic [10:0] tsa_ff, tsa_in;
   logic        ack_seen_ff, ack_seen_in;
   logic [31:0] srtt_ff, srtt_in, dev_ff, dev_in, cur_to_ff, cur_to_in;

   // item
   logic [5:0]  ack_num_ff, ack_num_in;
   logic [31:0] rtt_ff, rtt_in;

   // remainder unit
   logic [PID_W-1:0] mod_num_ff, mod_num_in;
   logic [6:0]  mod_div_ff, mod_div_in;
   logic [5:0]  mod_rem_ff, mod_rem_in, mod_step;
   logic [2:0]  mod_cnt_ff, mod_cnt_in;

   // walk
   logic [SLOT_W-1:0] j_ff, j_in, j_next;
   logic [SLOT_W:0]   cnt_ff, cnt_in;
   logic              rs_ff, rs_in, expn_ff, expn_in;

   // estimator
   logic signed [ACC_W-1:0] s_ff, s_in, d_ff, d_in, e_ff, e_in;

   // held and output words
   logic             pend_valid_ff, pend_valid_in;
   logic [2:0]       pend_kind_ff, pend_kind_in, new_kind_ff, new_kind_in;
   logic [PID_W-1:0] pend_pid_ff, pend_pid_in, new_pid_ff, new_pid_in;
   logic [5:0]       pend_seq_ff, pend_seq_in, new_seq_ff, new_seq_in;
   logic             pend_rs_ff, pend_rs_in, new_rs_ff, new_rs_in;
   logic [31:0]      pend_to_ff, pend_to_in;
   logic             out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [2:0]       out_kind_ff, out_kind_in;
   logic [PID_W-1:0] out_pid_ff, out_pid_in;
   logic [5:0]       out_seq_ff, out_seq_in;
   logic             out_rs_ff, out_rs_in;
   logic [31:0]      out_to_ff, out_to_in;

   // slot write controls
   logic             slot_we, start_load, abort_clr;
   logic [2:0]       slot_wst;
   logic [PID_W-1:0] slot_wpid;
   logic             slot_wrs;

   logic [5:0]  win;
   logic [6:0]  win2;
   logic [10:0] limit;
   logic        accept, out_free, walk_end, cand, need_ca, mismatch, is_fin;
   logic [2:0]  cur_st;
   logic [PID_W-1:0] cur_pid, slid_pid;
   logic        cfg_wr;
   logic signed [ACC_W-1:0] t_sum;

   function automatic logic signed [ACC_W-1:0] tdiv4(input logic signed [ACC_W-1:0] x);
      tdiv4 = (x + (x[ACC_W-1] ? 36'sd3 : 36'sd0)) >>> 2;
   endfunction

   function automatic logic signed [ACC_W-1:0] tdiv8(input logic signed [ACC_W-1:0] x);
      tdiv8 = (x + (x[ACC_W-1] ? 36'sd7 : 36'sd0)) >>> 3;
   endfunction

   function automatic logic signed [ACC_W-1:0] sabs(input logic signed [ACC_W-1:0] x);
      sabs = x[ACC_W-1] ? -x : x;
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [ACC_W-1:0] x);
      if (x[ACC_W-1])
         clamp32 = 32'd0;
      else if (x > $signed({4'd0, 32'hFFFF_FFFF}))
         clamp32 = 32'hFFFF_FFFF;
      else
         clamp32 = x[31:0];
   endfunction

   // ------------------------------------------------------------------
   assign win  = (window_size_ff == 6'd0) ? 6'd1 :
                 (window_size_ff > 6'(MAX_WINDOW)) ? 6'(MAX_WINDOW) : window_size_ff;
   assign win2 = {win, 1'b0};
   assign limit = adaptive_ff ? ADAPT_RETRY : {1'b0, retries_ff};
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign cur_st   = slot_status_ff[j_ff];
   assign cur_pid  = slot_pid_ff[j_ff];
   assign j_next   = (({1'b0, j_ff} + 6'd1) == win) ? '0 : j_ff + 1'b1;
   assign walk_end = (cnt_ff == win);
   assign cand     = (cur_st == SLOT_TO_SEND) || (cur_st == SLOT_EXPIRED);
   assign need_ca  = !ack_seen_ff && (cnt_ff == '0) && (j_ff == '0);
   assign is_fin   = (cur_st == SLOT_FINISHED);
   assign mismatch = (mod_rem_ff != ack_num_ff);
   assign slid_pid = cur_pid + PID_W'(win);
   assign t_sum    = s_ff + (d_ff <<< 2);
   assign cfg_wr   = psel && penable && pwrite && pready;

   always_comb begin
      logic [6:0] t;
      logic [5:0] r;
      r = mod_rem_ff;
      for (int k = 0; k < 5; k++) begin
         t = {r, mod_num_ff[PID_W-1-k]};
         if (t >= mod_div_ff) t = t - mod_div_ff;
         r = t[5:0];
      end
      mod_step = r;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_START, REQ_TIMER: state_in = ST_FINAL;
                  default:              state_in = ST_MOD;
               endcase
            end
         end
         ST_MOD:        if (mod_cnt_ff == 3'd4) state_in = mod_ret_ff;
         ST_SCAN_BASE:  state_in = ST_SCAN_SLOT;
         ST_SCAN_SLOT: begin
            if (walk_end)
               state_in = ST_FINAL;
            else if (cand)
               state_in = need_ca ? ST_PUSH : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (cur_st == SLOT_EXPIRED && tsa_ff >= limit)
               state_in = ST_PUSH;
            else
               state_in = ST_MOD;
         end
         ST_SCAN_SEND:  state_in = ST_PUSH;
         ST_ACK_SLOT:   state_in = ST_ACK_PID;
         ST_ACK_PID:    state_in = ST_MOD;
         ST_ACK_CHECK: begin
            if (is_fin || mismatch)
               state_in = ST_PUSH;
            else
               state_in = adaptive_ff ? ST_AD_E : ST_SLIDE_INIT;
         end
         ST_AD_E:       state_in = rs_ff ? ST_AD_X0 : ST_AD_S;
         ST_AD_S:       state_in = ST_AD_D;
         ST_AD_D:       state_in = ST_AD_X0;
         ST_AD_X0: begin
            if (expn_ff && s_ff < $signed({4'd0, BOOST_LIMIT}))
               state_in = ST_AD_X1;
            else
               state_in = ST_AD_CLAMP;
         end
         ST_AD_X1:      state_in = ST_AD_CLAMP;
         ST_AD_CLAMP:   state_in = ST_AD_T;
         ST_AD_T:       state_in = ST_SLIDE_INIT;
         ST_SLIDE_INIT: state_in = ST_MOD;
         ST_SLIDE_BASE: state_in = ST_SLIDE;
         ST_SLIDE:      if (walk_end || cur_st != SLOT_ACKED) state_in = ST_SLIDE_END;
         ST_SLIDE_END:  state_in = ST_PUSH;
         ST_PUSH:       if (!pend_valid_ff || out_free) state_in = push_ret_ff;
         ST_FINAL:      if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      mod_ret_in  = mod_ret_ff;
      push_ret_in = push_ret_ff;
      next_exp_in = next_exp_ff;
      tsa_in      = tsa_ff;
      ack_seen_in = ack_seen_ff;
      srtt_in     = srtt_ff;
      dev_in      = dev_ff;
      cur_to_in   = cur_to_ff;
      ack_num_in  = ack_num_ff;
      rtt_in      = rtt_ff;
      mod_num_in  = mod_num_ff;
      mod_div_in  = mod_div_ff;
      mod_rem_in  = mod_rem_ff;
      mod_cnt_in  = mod_cnt_ff;
      j_in        = j_ff;
      cnt_in      = cnt_ff;
      rs_in       = rs_ff;
      expn_in     = expn_ff;
      s_in        = s_ff;
      d_in        = d_ff;
      e_in        = e_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_pid_in   = pend_pid_ff;
      pend_seq_in   = pend_seq_ff;
      pend_rs_in    = pend_rs_ff;
      pend_to_in    = pend_to_ff;
      new_kind_in   = new_kind_ff;
      new_pid_in    = new_pid_ff;
      new_seq_in    = new_seq_ff;
      new_rs_in     = new_rs_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_pid_in    = out_pid_ff;
      out_seq_in    = out_seq_ff;
      out_rs_in     = out_rs_ff;
      out_to_in     = out_to_ff;
      out_last_in   = out_last_ff;
      slot_we    = 1'b0;
      slot_wst   = cur_st;
      slot_wpid  = cur_pid;
      slot_wrs   = slot_resent_ff[j_ff];
      start_load = 1'b0;
      abort_clr  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ack_num_in = req_ack_num;
               rtt_in     = req_rtt_sample;
               mod_rem_in = '0;
               mod_cnt_in = '0;
               mod_div_in = {1'b0, win};
               unique case (req_type)
                  REQ_START: begin
                     start_load  = 1'b1;
                     next_exp_in = '0;
                     tsa_in      = '0;
                     ack_seen_in = !client_ff;
                     cur_to_in   = init_to_ff;
                  end
                  REQ_SCAN: begin
                     mod_num_in = next_exp_ff;
                     mod_ret_in = ST_SCAN_BASE;
                  end
                  REQ_ACK: begin
                     mod_num_in = {{(PID_W-6){1'b0}}, req_ack_num};
                     mod_ret_in = ST_ACK_SLOT;
                  end
                  default: begin
                     if ({1'b0, req_slot_index} < win
                         && slot_status_ff[req_slot_index] == SLOT_WAITING) begin
                        j_in = req_slot_index;
                     end
                  end
               endcase
            end
         end
         ST_MOD: begin
            mod_rem_in = mod_step;
            mod_num_in = mod_num_ff << 5;
            mod_cnt_in = mod_cnt_ff + 3'd1;
         end
         ST_SCAN_BASE: begin
            j_in   = mod_rem_ff[SLOT_W-1:0];
            cnt_in = '0;
         end
         ST_SCAN_SLOT: begin
            if (!walk_end) begin
               if (!cand) begin
                  j_in   = j_next;
                  cnt_in = cnt_ff + 1'b1;
               end else if (need_ca) begin
                  new_kind_in = KIND_CONNACK;
                  new_pid_in  = '0;
                  new_seq_in  = '0;
                  new_rs_in   = 1'b0;
                  push_ret_in = ST_SCAN_CHK;
               end
            end
         end
         ST_SCAN_CHK: begin
            mod_num_in = cur_pid;
            mod_div_in = win2;
            mod_rem_in = '0;
            mod_cnt_in = '0;
            mod_ret_in = ST_SCAN_SEND;
            rs_in      = 1'b0;
            if (cur_st == SLOT_EXPIRED) begin
               if (tsa_ff >= limit) begin
                  abort_clr   = 1'b1;
                  new_kind_in = KIND_ABORT;
                  new_pid_in  = '0;
                  new_seq_in  = '0;
                  new_rs_in   = 1'b0;
                  push_ret_in = ST_FINAL;
               end else begin
                  tsa_in   = tsa_ff + 11'd1;
                  rs_in    = 1'b1;
                  slot_we  = 1'b1;
                  slot_wrs = 1'b1;
               end
            end
         end
         ST_SCAN_SEND: begin
            new_kind_in = KIND_SEND;
            new_pid_in  = cur_pid;
            new_seq_in  = mod_rem_ff;
            new_rs_in   = rs_ff;
            push_ret_in = ST_SCAN_SLOT;
            slot_we     = 1'b1;
            slot_wst    = SLOT_WAITING;
            j_in        = j_next;
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_ACK_SLOT: j_in = mod_rem_ff[SLOT_W-1:0];
         ST_ACK_PID: begin
            mod_num_in = cur_pid;
            mod_div_in = win2;
            mod_rem_in = '0;
            mod_cnt_in = '0;
            mod_ret_in = ST_ACK_CHECK;
         end
         ST_ACK_CHECK: begin
            if (is_fin || mismatch) begin
               new_kind_in = KIND_IGNORE;
               new_pid_in  = '0;
               new_seq_in  = '0;
               new_rs_in   = 1'b0;
               push_ret_in = ST_FINAL;
            end else begin
               slot_we     = 1'b1;
               slot_wst    = SLOT_ACKED;
               rs_in       = slot_resent_ff[j_ff];
               expn_in     = (tsa_ff != '0);
               ack_seen_in = 1'b1;
               tsa_in      = '0;
               s_in        = $signed({4'd0, srtt_ff});
               d_in        = $signed({4'd0, dev_ff});
            end
         end
         ST_AD_E:  e_in = $signed({4'd0, rtt_ff}) - s_ff;
         ST_AD_S: begin
            s_in = s_ff + tdiv8(e_ff);
            e_in = sabs(e_ff);
         end
         ST_AD_D:  d_in = d_ff + tdiv4(e_ff - d_ff);
         ST_AD_X0: begin
            if (expn_ff && s_ff < $signed({4'd0, BOOST_LIMIT})) begin
               e_in = s_ff >>> 1;
               s_in = s_ff + (s_ff >>> 3);
            end
         end
         ST_AD_X1: d_in = d_ff + tdiv4(sabs(e_ff) - d_ff);
         ST_AD_CLAMP: begin
            srtt_in = clamp32(s_ff);
            dev_in  = clamp32(d_ff);
            s_in    = $signed({4'd0, clamp32(s_ff)});
            d_in    = $signed({4'd0, clamp32(d_ff)});
         end
         ST_AD_T: begin
            cur_to_in = (t_sum > $signed({4'd0, 32'hFFFF_FFFF})) ? 32'hFFFF_FFFF
                                                                 : t_sum[31:0];
         end
         ST_SLIDE_INIT: begin
            mod_num_in = next_exp_ff;
            mod_div_in = {1'b0, win};
            mod_rem_in = '0;
            mod_cnt_in = '0;
            mod_ret_in = ST_SLIDE_BASE;
         end
         ST_SLIDE_BASE: begin
            j_in   = mod_rem_ff[SLOT_W-1:0];
            cnt_in = '0;
         end
         ST_SLIDE: begin
            if (!walk_end && cur_st == SLOT_ACKED) begin
               slot_we   = 1'b1;
               slot_wpid = slid_pid;
               if ({1'b0, packet_count_ff} >= ({1'b0, slid_pid} + 26'd1)) begin
                  slot_wst = SLOT_TO_SEND;
                  slot_wrs = 1'b0;
               end else begin
                  slot_wst = SLOT_FINISHED;
               end
               j_in   = j_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SLIDE_END: begin
            next_exp_in = next_exp_ff + PID_W'(cnt_ff);
            new_kind_in = ((next_exp_ff + PID_W'(cnt_ff)) >= {1'b0, packet_count_ff})
                          ? KIND_DONE : KIND_ACCEPT;
            new_pid_in  = '0;
            new_seq_in  = '0;
            new_rs_in   = 1'b0;
            push_ret_in = ST_FINAL;
         end
         ST_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = pend_kind_ff;
                  out_pid_in   = pend_pid_ff;
                  out_seq_in   = pend_seq_ff;
                  out_rs_in    = pend_rs_ff;
                  out_to_in    = pend_to_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_kind_in  = new_kind_ff;
               pend_pid_in   = new_pid_ff;
               pend_seq_in   = new_seq_ff;
               pend_rs_in    = new_rs_ff;
               pend_to_in    = cur_to_ff;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  out_kind_in = pend_kind_ff;
                  out_pid_in  = pend_pid_ff;
                  out_seq_in  = pend_seq_ff;
                  out_rs_in   = pend_rs_ff;
                  out_to_in   = pend_to_ff;
               end else begin
                  out_kind_in = KIND_IDLE;
                  out_pid_in  = '0;
                  out_seq_in  = '0;
                  out_rs_in   = 1'b0;
                  out_to_in   = cur_to_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // timer expiry marks the slot in the idle cycle itself
   logic timer_hit;
   assign timer_hit = accept && (req_type == REQ_TIMER)
                      && ({1'b0, req_slot_index} < win)
                      && (slot_status_ff[req_slot_index] == SLOT_WAITING);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            slot_status_ff[i] <= SLOT_FINISHED;
            slot_pid_ff[i]    <= '0;
            slot_resent_ff[i] <= 1'b0;
         end
      end else if (start_load) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            slot_resent_ff[i] <= 1'b0;
            slot_pid_ff[i]    <= PID_W'(i);
            slot_status_ff[i] <= (i < int'(win) && int'(packet_count_ff) >= i + 1)
                                 ? SLOT_TO_SEND : SLOT_FINISHED;
         end
      end else if (abort_clr) begin
         for (int i = 0; i < MAX_WINDOW; i++) slot_status_ff[i] <= SLOT_FINISHED;
      end else if (timer_hit) begin
         slot_status_ff[req_slot_index] <= SLOT_EXPIRED;
      end else if (slot_we) begin
         slot_status_ff[j_ff] <= slot_wst;
         slot_pid_ff[j_ff]    <= slot_wpid;
         slot_resent_ff[j_ff] <= slot_wrs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= 6'd4;
         packet_count_ff <= 24'd1;
         adaptive_ff     <= 1'b0;
         client_ff       <= 1'b0;
         retries_ff      <= 10'd10;
         init_to_ff      <= 32'd5000;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_WINDOW:  window_size_ff  <= pwdata[5:0];
            REG_PACKETS: packet_count_ff <= pwdata[23:0];
            REG_ADAPT:   adaptive_ff     <= pwdata[0];
            REG_CLIENT:  client_ff       <= pwdata[0];
            REG_RETRIES: retries_ff      <= pwdata[9:0];
            REG_TIMEOUT: init_to_ff      <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_WINDOW:  prdata = {26'd0, window_size_ff};
         REG_PACKETS: prdata = {8'd0, packet_count_ff};
         REG_ADAPT:   prdata = {31'd0, adaptive_ff};
         REG_CLIENT:  prdata = {31'd0, client_ff};
         REG_RETRIES: prdata = {22'd0, retries_ff};
         REG_TIMEOUT: prdata = init_to_ff;
         default:     prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mod_ret_ff    <= ST_IDLE;
         push_ret_ff   <= ST_IDLE;
         next_exp_ff   <= '0;
         tsa_ff        <= '0;
         ack_seen_ff   <= 1'b0;
         srtt_ff       <= SRTT_RESET;
         dev_ff        <= DEV_RESET;
         cur_to_ff     <= 32'd5000;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mod_ret_ff    <= mod_ret_in;
         push_ret_ff   <= push_ret_in;
         next_exp_ff   <= next_exp_in;
         tsa_ff        <= tsa_in;
         ack_seen_ff   <= ack_seen_in;
         srtt_ff       <= srtt_in;
         dev_ff        <= dev_in;
         cur_to_ff     <= cur_to_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_num_ff   <= ack_num_in;
      rtt_ff       <= rtt_in;
      mod_num_ff   <= mod_num_in;
      mod_div_ff   <= mod_div_in;
      mod_rem_ff   <= mod_rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      j_ff         <= j_in;
      cnt_ff       <= cnt_in;
      rs_ff        <= rs_in;
      expn_ff      <= expn_in;
      s_ff         <= s_in;
      d_ff         <= d_in;
      e_ff         <= e_in;
      pend_kind_ff <= pend_kind_in;
      pend_pid_ff  <= pend_pid_in;
      pend_seq_ff  <= pend_seq_in;
      pend_rs_ff   <= pend_rs_in;
      pend_to_ff   <= pend_to_in;
      new_kind_ff  <= new_kind_in;
      new_pid_ff   <= new_pid_in;
      new_seq_ff   <= new_seq_in;
      new_rs_ff    <= new_rs_in;
      out_kind_ff  <= out_kind_in;
      out_pid_ff   <= out_pid_in;
      out_seq_ff   <= out_seq_in;
      out_rs_ff    <= out_rs_in;
      out_to_ff    <= out_to_in;
      out_last_ff  <= out_last_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_packet_id     = out_pid_ff;
   assign rsp_seq_num       = out_seq_ff;
   assign rsp_is_resend     = out_rs_ff;
   assign rsp_timeout_value = out_to_ff;
   assign rsp_last          = out_last_ff;

endmodule
